FILE: src/mesh_neighbor_table_update_macros.svh
// Assertion macros used by the mesh neighbour table update controller.
// Expects clk and arst_n in the scope of each use.
`ifndef MESH_NEIGHBOR_TABLE_UPDATE_MACROS_SVH
`define MESH_NEIGHBOR_TABLE_UPDATE_MACROS_SVH

// same-cycle implication
`define MNTU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MNTU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/mntu_pkg.sv
// Package for the mesh neighbour table update block: sizes, codes, entry layout
// and the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package mntu_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int SLOT_W      = 4;
	localparam int ADDR_W      = 8;
	localparam int TICKS_W     = 16;
	localparam int COST_W      = 2;
	localparam int SVC_W       = 8;

	localparam logic [TICKS_W-1:0] REFRESH_RESET = 16'd30;
	localparam logic [ADDR_W-1:0]  NO_SECOND_HOP = 8'hFF;

	localparam logic [COST_W-1:0] COST_NONE  = 2'd0;
	localparam logic [COST_W-1:0] COST_ONE   = 2'd1;
	localparam logic [COST_W-1:0] COST_TWO   = 2'd2;
	localparam logic [COST_W-1:0] COST_THREE = 2'd3;

	typedef enum logic [1:0] {
		ACT_REFRESH = 2'd0,
		ACT_INSERT  = 2'd1,
		ACT_SKIP    = 2'd2,
		ACT_FULL    = 2'd3
	} action_t;

	typedef enum logic {
		OP_SENDER   = 1'b0,
		OP_NEIGHBOR = 1'b1
	} op_t;

	typedef struct packed {
		logic [TICKS_W-1:0] ticks;
		logic [ADDR_W-1:0]  dest;
		logic [ADDR_W-1:0]  next_hop;
		logic [ADDR_W-1:0]  second_hop;
		logic [COST_W-1:0]  cost;
		logic [SVC_W-1:0]   services;
	} entry_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

FILE: src/mntu_dp.sv
// Datapath: item and config registers, route table memory, scan evaluation,
// update decision and output register. Depends on mntu_pkg.
`timescale 1ns / 1ps

module mntu_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mntu_pkg::cmd_t                cmd,
	output mntu_pkg::sts_t                sts,
	input  logic                          operation,
	input  logic [mntu_pkg::ADDR_W-1:0]   origin_addr,
	input  logic [mntu_pkg::ADDR_W-1:0]   hop_addr,
	input  logic [mntu_pkg::ADDR_W-1:0]   second_hop_addr,
	input  logic [mntu_pkg::SVC_W-1:0]    service_bits,
	input  logic                          cfg_we,
	input  logic [mntu_pkg::TICKS_W-1:0]  cfg_wdata,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    action,
	output logic [mntu_pkg::SLOT_W-1:0]   slot,
	output logic [mntu_pkg::COST_W-1:0]   route_cost
);

	mntu_pkg::op_t                  op_q;
	logic [mntu_pkg::ADDR_W-1:0]    sender_q;
	logic [mntu_pkg::ADDR_W-1:0]    hop_q;
	logic [mntu_pkg::ADDR_W-1:0]    second_q;
	logic [mntu_pkg::SVC_W-1:0]     svc_q;
	logic [mntu_pkg::TICKS_W-1:0]   refresh_q;

	mntu_pkg::entry_t               route_mem_q [mntu_pkg::TABLE_DEPTH];
	logic [mntu_pkg::TABLE_DEPTH-1:0] valid_q;
	logic [mntu_pkg::IDX_W-1:0]     cnt_q;

	logic                           rd_s1;
	logic                           rd_live_s1;
	logic [mntu_pkg::IDX_W-1:0]     rd_idx_s1;
	mntu_pkg::entry_t               rd_word_s1;

	logic                           hit_q;
	logic                           hit_second_q;
	logic [mntu_pkg::IDX_W-1:0]     hit_idx_q;
	mntu_pkg::entry_t               hit_word_q;
	logic                           free_q;
	logic [mntu_pkg::IDX_W-1:0]     free_idx_q;
	mntu_pkg::entry_t               free_word_q;

	logic                           out_valid_q;
	mntu_pkg::action_t              action_q;
	logic [mntu_pkg::SLOT_W-1:0]    slot_q;
	logic [mntu_pkg::COST_W-1:0]    cost_q;

	logic                           match_first;
	logic                           match_second;
	logic                           entry_hit;
	logic                           entry_free;

	logic                           wr_en;
	logic [mntu_pkg::IDX_W-1:0]     wr_idx;
	mntu_pkg::entry_t               wr_word;
	mntu_pkg::action_t              res_act;
	logic [mntu_pkg::COST_W-1:0]    res_cost;

	assign sts.scan_last = (cnt_q == mntu_pkg::IDX_W'(mntu_pkg::TABLE_DEPTH - 1));
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign match_first  = (op_q == mntu_pkg::OP_SENDER) ? (rd_word_s1.dest == sender_q)
	                                                    : (rd_word_s1.dest == hop_q);
	assign match_second = (op_q == mntu_pkg::OP_NEIGHBOR) && (rd_word_s1.dest == second_q);
	assign entry_hit    = rd_s1 && rd_live_s1 && (match_first || match_second);
	assign entry_free   = rd_s1 && !rd_live_s1;

	always_comb begin
		wr_en    = 1'b0;
		wr_idx   = free_idx_q;
		wr_word  = free_word_q;
		res_act  = mntu_pkg::ACT_FULL;
		res_cost = mntu_pkg::COST_NONE;
		if (hit_q) begin
			wr_idx  = hit_idx_q;
			wr_word = hit_word_q;
		end
		wr_word.ticks    = refresh_q;
		wr_word.next_hop = sender_q;
		priority if (hit_q) begin
			if (op_q == mntu_pkg::OP_SENDER) begin
				wr_en         = 1'b1;
				wr_word.dest  = sender_q;
				wr_word.cost  = mntu_pkg::COST_ONE;
				res_act       = mntu_pkg::ACT_REFRESH;
				res_cost      = mntu_pkg::COST_ONE;
			end else if (!hit_second_q) begin
				if (hit_word_q.cost == mntu_pkg::COST_ONE) begin
					res_act  = mntu_pkg::ACT_SKIP;
					res_cost = mntu_pkg::COST_ONE;
				end else begin
					wr_en            = 1'b1;
					wr_word.dest     = hop_q;
					wr_word.cost     = mntu_pkg::COST_TWO;
					wr_word.services = svc_q;
					res_act          = mntu_pkg::ACT_REFRESH;
					res_cost         = mntu_pkg::COST_TWO;
				end
			end else begin
				if (hit_word_q.cost != mntu_pkg::COST_THREE) begin
					res_act  = mntu_pkg::ACT_SKIP;
					res_cost = hit_word_q.cost;
				end else begin
					wr_en              = 1'b1;
					wr_word.dest       = second_q;
					wr_word.second_hop = hop_q;
					wr_word.cost       = mntu_pkg::COST_THREE;
					wr_word.services   = svc_q;
					res_act            = mntu_pkg::ACT_REFRESH;
					res_cost           = mntu_pkg::COST_THREE;
				end
			end
		end else if (free_q) begin
			wr_en   = 1'b1;
			res_act = mntu_pkg::ACT_INSERT;
			if (op_q == mntu_pkg::OP_SENDER) begin
				wr_word.dest = sender_q;
				wr_word.cost = mntu_pkg::COST_ONE;
			end else if (second_q == mntu_pkg::NO_SECOND_HOP) begin
				wr_word.dest     = hop_q;
				wr_word.cost     = mntu_pkg::COST_TWO;
				wr_word.services = svc_q;
			end else begin
				wr_word.dest       = second_q;
				wr_word.second_hop = hop_q;
				wr_word.cost       = mntu_pkg::COST_THREE;
				wr_word.services   = svc_q;
			end
			res_cost = wr_word.cost;
		end else begin
			wr_en = 1'b0;
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= mntu_pkg::op_t'(operation);
			sender_q <= origin_addr;
			hop_q    <= hop_addr;
			second_q <= second_hop_addr;
			svc_q    <= service_bits;
		end
	end

	// table memory: one read or one write per cycle
	always_ff @(posedge clk) begin
		if (cmd.commit && wr_en) begin
			route_mem_q[wr_idx] <= wr_word;
		end
		if (cmd.rd) begin
			rd_word_s1 <= route_mem_q[cnt_q];
		end
	end

	// scan records and result payload
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_idx_s1  <= cnt_q;
			rd_live_s1 <= valid_q[cnt_q];
		end
		if (entry_hit && !hit_q) begin
			hit_second_q <= !match_first;
			hit_idx_q    <= rd_idx_s1;
			hit_word_q   <= rd_word_s1;
		end
		if (entry_free && !free_q) begin
			free_idx_q  <= rd_idx_s1;
			free_word_q <= rd_word_s1;
		end
		if (cmd.commit) begin
			action_q <= res_act;
			cost_q   <= res_cost;
			slot_q   <= (res_act == mntu_pkg::ACT_FULL) ? '0 : mntu_pkg::SLOT_W'(wr_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_q   <= mntu_pkg::REFRESH_RESET;
			valid_q     <= '0;
			cnt_q       <= '0;
			rd_s1       <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				refresh_q <= cfg_wdata;
			end
			rd_s1 <= cmd.rd;
			if (cmd.load) begin
				cnt_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else begin
				if (cmd.rd) begin
					cnt_q <= cnt_q + mntu_pkg::IDX_W'(1);
				end
				if (entry_hit) begin
					hit_q <= 1'b1;
				end
				if (entry_free) begin
					free_q <= 1'b1;
				end
			end
			if (cmd.commit && wr_en) begin
				valid_q[wr_idx] <= |refresh_q;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign action     = action_q;
	assign slot       = slot_q;
	assign route_cost = cost_q;

endmodule

FILE: src/mntu_ctrl.sv
// Controller: sequences load, table scan, drain and commit for one word.
// Depends on mntu_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "mesh_neighbor_table_update_macros.svh"

module mntu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output mntu_pkg::cmd_t cmd,
	input  mntu_pkg::sts_t sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   accept;

	assign accept     = (state_q == ST_IDLE) && in_valid;
	assign in_stall   = (state_q != ST_IDLE);
	assign cmd.load   = accept;
	assign cmd.rd     = (state_q == ST_SCAN);
	assign cmd.commit = (state_q == ST_COMMIT) && sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`MNTU_ASSERT_NEXT(a_accept_scan, accept, state_q == ST_SCAN, "accepted word did not start a scan")
	`MNTU_ASSERT_NEXT(a_scan_end, cmd.rd && sts.scan_last, state_q == ST_DRAIN, "scan overran the table")
	`MNTU_ASSERT_NOW(a_commit_free, cmd.commit, sts.out_free && !cmd.rd, "commit into a held result")

endmodule

FILE: src/mesh_neighbor_table_update.sv
// Top level of the mesh neighbour table update block.
// Depends on mntu_pkg, mntu_ctrl and mntu_dp.
`timescale 1ns / 1ps
//
//   channel  handshake              payload
//   input    in_valid / in_stall    operation, origin_addr, hop_addr,
//                                   second_hop_addr, service_bits
//   output   out_valid / out_stall  action, slot, route_cost
//   config   cfg_we                 cfg_wdata (refresh_ticks)
//
// Each word is handled by a serial scan of the table memory through its single
// read port, one entry a cycle; the result is registered at commit. A held
// result stalls the commit, but the next word is still taken once the commit
// has gone through.
// arst_n clears control state and marks every table entry invalid at once.

module mesh_neighbor_table_update (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          operation,
	input  logic [mntu_pkg::ADDR_W-1:0]   origin_addr,
	input  logic [mntu_pkg::ADDR_W-1:0]   hop_addr,
	input  logic [mntu_pkg::ADDR_W-1:0]   second_hop_addr,
	input  logic [mntu_pkg::SVC_W-1:0]    service_bits,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    action,
	output logic [mntu_pkg::SLOT_W-1:0]   slot,
	output logic [mntu_pkg::COST_W-1:0]   route_cost,
	input  logic                          cfg_we,
	input  logic [mntu_pkg::TICKS_W-1:0]  cfg_wdata
);

	mntu_pkg::cmd_t cmd;
	mntu_pkg::sts_t sts;

	mntu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	mntu_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.operation       (operation),
		.origin_addr     (origin_addr),
		.hop_addr        (hop_addr),
		.second_hop_addr (second_hop_addr),
		.service_bits    (service_bits),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.action          (action),
		.slot            (slot),
		.route_cost      (route_cost)
	);

endmodule
